// ===== sv/gre_header_length_parser_macros.svh =====
// Assertion macros for the GRE header length parser.
// Included by files that check their own logic; needs clk and rst_n in scope.
`ifndef GRE_HEADER_LENGTH_PARSER_MACROS_SVH
`define GRE_HEADER_LENGTH_PARSER_MACROS_SVH

// Same-cycle implication, checked out of reset
`define GHLP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset
`define GHLP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/ghlp_pkg.sv =====
// Shared constants for the GRE header length parser.
// No dependencies; used by gre_header_length_parser.
package ghlp_pkg;

  // Routing walk limit and the index width that follows from it
  localparam int MAX_ROUTING_ENTRIES = 4;
  localparam int RIDX_W = $clog2(MAX_ROUTING_ENTRIES + 1);

  // Field widths
  localparam int BYTE_W  = 8;
  localparam int PROTO_W = 16;
  localparam int LEN_W   = 11;
  localparam int SKIP_W  = 8;
  localparam int OUT_W   = 32;

  localparam logic [LEN_W-1:0] LEN_MAX = 11'd2047;

  // Header byte 0 and byte 1 flag masks
  localparam logic [BYTE_W-1:0] HDR_C = 8'h80;
  localparam logic [BYTE_W-1:0] HDR_R = 8'h40;
  localparam logic [BYTE_W-1:0] HDR_K = 8'h20;
  localparam logic [BYTE_W-1:0] HDR_S = 8'h10;
  localparam logic [BYTE_W-1:0] HDR_A = 8'h80;

  // Bit positions in the stored option flags
  localparam int FL_C = 4;
  localparam int FL_R = 3;
  localparam int FL_K = 2;
  localparam int FL_S = 1;
  localparam int FL_A = 0;

  // Section lengths in bytes
  localparam logic [SKIP_W-1:0] WORD_BYTES = 8'd4;

  // Result status codes
  localparam logic ST_COMPLETE  = 1'b0;
  localparam logic ST_TRUNCATED = 1'b1;

endpackage

// ===== sv/gre_header_length_parser.sv =====
// GRE header length parser: top level, byte stream in, one result per header out.
// Depends on ghlp_pkg and gre_header_length_parser_macros.svh.
//
// Bytes of a packet enter on the in_ stream one beat per byte; in_tuser marks the
// first byte of a GRE header and in_tlast the last byte of the packet. The block
// follows the flags, the optional checksum, key and sequence words, up to
// ghlp_pkg::MAX_ROUTING_ENTRIES routing entries and the acknowledgment word, and on
// the byte that completes the header (or on an early packet end) emits one beat
// with the protocol, the header length (saturating at 2047) and a status flag.
// A beat is accepted in every cycle while the result side keeps up, and a result
// passes through the input register and then the result register after its last
// byte is accepted.
module gre_header_length_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] header_byte
  input  logic        in_tuser,   // first
  input  logic        in_tlast,   // end_of_packet
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [15:0] payload_protocol, [26:16] header_length,
                                  // [31:27] zero
  output logic        out_tuser   // status
);

  localparam int RW = ghlp_pkg::RIDX_W;

  typedef enum logic [5:0] {
    PH_IDLE  = 6'b000001,
    PH_BASE  = 6'b000010,
    PH_OPT   = 6'b000100,
    PH_RHDR  = 6'b001000,
    PH_RDATA = 6'b010000,
    PH_ACK   = 6'b100000
  } phase_t;

  // Input register
  logic                            s1_valid_r, s1_valid_nxt;
  logic [ghlp_pkg::BYTE_W-1:0]     s1_byte_r;
  logic                            s1_first_r;
  logic                            s1_eop_r;
  logic                            s1_adv;

  // Parser state
  phase_t                          phase_r, phase_nxt;
  logic [ghlp_pkg::LEN_W-1:0]      count_r, count_nxt;
  logic [4:0]                      flags_r, flags_nxt;
  logic [ghlp_pkg::PROTO_W-1:0]    proto_r, proto_nxt;
  logic [RW-1:0]                   ridx_r, ridx_nxt;
  logic [ghlp_pkg::PROTO_W-1:0]    family_r, family_nxt;
  logic [ghlp_pkg::SKIP_W-1:0]     skip_r, skip_nxt;

  // Result register
  logic                            out_valid_r, out_valid_nxt;
  logic [ghlp_pkg::PROTO_W-1:0]    out_proto_r, out_proto_nxt;
  logic [ghlp_pkg::LEN_W-1:0]      out_len_r, out_len_nxt;
  logic                            out_status_r, out_status_nxt;
  logic                            res_valid;

  // Advance the input register whenever the result slot is free or being drained
  assign s1_adv    = !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || s1_adv;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_tready) begin
      s1_valid_nxt = in_tvalid;
    end
  end

  // Process one byte: walk the header sections
  always_comb begin
    phase_t                       ph;
    logic [ghlp_pkg::LEN_W-1:0]   cnt;
    logic [ghlp_pkg::LEN_W-1:0]   pos;
    logic [4:0]                   fl;
    logic [ghlp_pkg::PROTO_W-1:0] pr;
    logic [RW-1:0]                ri;
    logic [ghlp_pkg::PROTO_W-1:0] fam;
    logic [ghlp_pkg::SKIP_W-1:0]  sk;
    logic [ghlp_pkg::SKIP_W-1:0]  opt_n;
    logic                         go_opt, go_rt, go_ack, done, active;

    ph = phase_r;  cnt = count_r; fl = flags_r; pr = proto_r;
    ri = ridx_r;   fam = family_r; sk = skip_r;
    pos = '0; opt_n = '0;
    go_opt = 1'b0; go_rt = 1'b0; go_ack = 1'b0; done = 1'b0;
    active = 1'b0;
    res_valid = 1'b0;

    if (s1_valid_r && s1_adv) begin
      // A first byte abandons any header in progress
      if (s1_first_r) begin
        ph = PH_BASE; cnt = '0; fl = '0; pr = '0; ri = '0; fam = '0; sk = '0;
      end
      active = (ph != PH_IDLE);

      if (active) begin
        pos = cnt;
        if (cnt < ghlp_pkg::LEN_MAX) begin
          cnt = cnt + 1'b1;
        end

        unique case (ph)
          PH_BASE: begin
            if (pos == 11'd0) begin
              fl[ghlp_pkg::FL_C] = |(s1_byte_r & ghlp_pkg::HDR_C);
              fl[ghlp_pkg::FL_R] = |(s1_byte_r & ghlp_pkg::HDR_R);
              fl[ghlp_pkg::FL_K] = |(s1_byte_r & ghlp_pkg::HDR_K);
              fl[ghlp_pkg::FL_S] = |(s1_byte_r & ghlp_pkg::HDR_S);
            end else if (pos == 11'd1) begin
              if (|(s1_byte_r & ghlp_pkg::HDR_A)) begin
                fl[ghlp_pkg::FL_A] = 1'b1;
              end
            end else if (pos == 11'd2) begin
              pr = {s1_byte_r, 8'h00};
            end else begin
              pr = {pr[15:8], s1_byte_r};
              go_opt = 1'b1;
            end
          end
          PH_OPT: begin
            if (sk != '0) begin
              sk = sk - 1'b1;
            end
            go_rt = (sk == '0);
          end
          PH_RHDR: begin
            if (sk == 8'd4) begin
              fam = {s1_byte_r, 8'h00};
            end else if (sk == 8'd3) begin
              fam = {fam[15:8], s1_byte_r};
            end
            if (sk != '0) begin
              sk = sk - 1'b1;
            end
            if (sk == '0) begin
              if (s1_byte_r != '0) begin
                ph = PH_RDATA;
                sk = s1_byte_r;
              end else begin
                // Entry without data: null entry or routing limit ends the walk
                ri = ri + 1'b1;
                if (fam == '0 || ri >= RW'(ghlp_pkg::MAX_ROUTING_ENTRIES)) begin
                  go_ack = 1'b1;
                end else begin
                  ph = PH_RHDR; sk = ghlp_pkg::WORD_BYTES; fam = '0;
                end
              end
            end
          end
          PH_RDATA: begin
            if (sk != '0) begin
              sk = sk - 1'b1;
            end
            if (sk == '0) begin
              ri = ri + 1'b1;
              if (ri >= RW'(ghlp_pkg::MAX_ROUTING_ENTRIES)) begin
                go_ack = 1'b1;
              end else begin
                ph = PH_RHDR; sk = ghlp_pkg::WORD_BYTES; fam = '0;
              end
            end
          end
          PH_ACK: begin
            if (sk != '0) begin
              sk = sk - 1'b1;
            end
            done = (sk == '0);
          end
          default: begin
            ph = PH_IDLE;
          end
        endcase

        // Enter the optional words: checksum/offset, key, sequence
        if (go_opt) begin
          opt_n = ((fl[ghlp_pkg::FL_C] || fl[ghlp_pkg::FL_R]) ? 8'd4 : 8'd0)
                + (fl[ghlp_pkg::FL_K] ? 8'd4 : 8'd0)
                + (fl[ghlp_pkg::FL_S] ? 8'd4 : 8'd0);
          if (opt_n != '0) begin
            ph = PH_OPT; sk = opt_n;
          end else begin
            go_rt = 1'b1;
          end
        end
        // Enter the routing walk
        if (go_rt) begin
          if (fl[ghlp_pkg::FL_R]) begin
            ph = PH_RHDR; sk = ghlp_pkg::WORD_BYTES; ri = '0; fam = '0;
          end else begin
            go_ack = 1'b1;
          end
        end
        // Enter the acknowledgment word
        if (go_ack) begin
          if (fl[ghlp_pkg::FL_A]) begin
            ph = PH_ACK; sk = ghlp_pkg::WORD_BYTES;
          end else begin
            done = 1'b1;
          end
        end

        if (done || s1_eop_r) begin
          res_valid = 1'b1;
          ph = PH_IDLE;
        end
      end
    end

    phase_nxt = ph;  count_nxt = cnt; flags_nxt = fl; proto_nxt = pr;
    ridx_nxt = ri;   family_nxt = fam; skip_nxt = sk;

    out_proto_nxt  = pr;
    out_len_nxt    = cnt;
    out_status_nxt = done ? ghlp_pkg::ST_COMPLETE : ghlp_pkg::ST_TRUNCATED;
  end

  // Load or drain the result register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_adv) begin
      out_valid_nxt = res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      phase_r     <= PH_IDLE;
      count_r     <= '0;
      flags_r     <= '0;
      proto_r     <= '0;
      ridx_r      <= '0;
      family_r    <= '0;
      skip_r      <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      phase_r     <= phase_nxt;
      count_r     <= count_nxt;
      flags_r     <= flags_nxt;
      proto_r     <= proto_nxt;
      ridx_r      <= ridx_nxt;
      family_r    <= family_nxt;
      skip_r      <= skip_nxt;
    end
  end

  // Payload registers: capture the beat and the result
  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_byte_r  <= in_tdata;
      s1_first_r <= in_tuser;
      s1_eop_r   <= in_tlast;
    end
    if (s1_adv && res_valid) begin
      out_proto_r  <= out_proto_nxt;
      out_len_r    <= out_len_nxt;
      out_status_r <= out_status_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b0, out_len_r, out_proto_r};
  assign out_tuser  = out_status_r;

  `include "gre_header_length_parser_macros.svh"

  // A complete header is never shorter than the base four bytes
  `GHLP_ASSERT_NOW(a_complete_min_len, out_valid_r && out_status_r == ghlp_pkg::ST_COMPLETE, out_len_r >= 11'd4, "complete header shorter than four bytes")
  // Mid-header the byte counter has always counted the first byte
  `GHLP_ASSERT_NOW(a_active_counted, phase_r != PH_IDLE, count_r != '0, "header in progress with zero byte count")
  // The routing walk never passes its limit
  `GHLP_ASSERT_NOW(a_ridx_limit, 1'b1, ridx_r <= RW'(ghlp_pkg::MAX_ROUTING_ENTRIES), "routing index beyond limit")
  // A byte held back by a full result slot stays in the input register
  `GHLP_ASSERT_NEXT(a_s1_hold, s1_valid_r && !s1_adv, s1_valid_r && $stable(s1_byte_r), "stalled byte lost")

endmodule
